>>> sv/sponge_hash_384bit_permutation_assert.svh
// Assertion macros used by the checker file of the sponge hash block.
`ifndef SPONGE_HASH_384BIT_PERMUTATION_ASSERT_SVH
`define SPONGE_HASH_384BIT_PERMUTATION_ASSERT_SVH

// Checked at every clock edge outside of reset.
`define SH384_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SH384_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/sh384_pkg.sv
package sh384_pkg;

  localparam int NUM_WORDS     = 12;
  localparam int RATE_BYTES    = 16;
  localparam int ROUNDS        = 24;
  localparam int MAX_OUT_BYTES = 64;

  localparam int POS_W  = $clog2(RATE_BYTES);
  localparam int RND_W  = $clog2(ROUNDS);
  localparam int LEN_W  = $clog2(MAX_OUT_BYTES + 1);
  localparam int WIDX_W = $clog2(NUM_WORDS);
  localparam int CFG_W  = 7;

  localparam logic [31:0] ROUND_CONST = 32'hb7e15100;
  localparam logic [7:0]  PAD_FIRST   = 8'h80;
  localparam logic [7:0]  PAD_LAST    = 8'h01;
  localparam logic [CFG_W-1:0] OUT_LENGTH_RESET = CFG_W'(32);

  typedef logic [NUM_WORDS-1:0][31:0] state_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] hash_byte;
    logic       last_byte;
  } out_item_t;

  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_code_t;

  typedef enum logic [2:0] {
    DP_HOLD,
    DP_ABSORB,
    DP_PAD,
    DP_ROUND,
    DP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic [RND_W-1:0] rnd;
  } dp_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PERM,
    ST_SQUEEZE,
    ST_CLEAR
  } ctrl_state_t;

endpackage

>>> sv/sponge_hash_384bit_permutation.sv
// Sponge hash over a 384-bit state with a 24-round column-mix permutation.
// Input channel (in_valid / in_stall / in_data): each transaction carries a
// command and a data byte. An absorb XORs the byte into the 16-byte rate; a
// finish pads the message, permutes and squeezes the hash.
// Output channel (out_valid / out_stall / out_data): one transaction per hash
// byte, last_byte set on the final one. Configuration channel (cfg_valid /
// cfg_ready / cfg_out_length) sets the hash length, saturated to 64 bytes;
// write it only while no message is being finished.
// An absorb that fills the rate starts the permutation, which runs one round per
// cycle in a single round unit; other absorbs leave the input free. A finish
// pads the message and permutes before the first hash byte; bytes then leave one
// per cycle while the receiver does not stall, with a permutation after every 16th.
// A zero-length finish permutes, wipes the state and gives no output.
// While the hash is squeezed, in_stall stays high. When the receiver stalls,
// out_data holds and the block simply waits. After the last byte the state
// is wiped. Synchronous reset clears the state, the rate position and sets
// the hash length to 32 bytes.
module sponge_hash_384bit_permutation (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sh384_pkg::in_item_t         in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sh384_pkg::out_item_t        out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sh384_pkg::CFG_W-1:0] cfg_out_length
);

  sh384_pkg::dp_cmd_t cmd;
  logic [7:0]         rd_byte;
  logic               out_last;

  sh384_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_out_length (cfg_out_length),
    .cmd            (cmd)
  );

  sh384_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_byte (rd_byte)
  );

  assign out_data.hash_byte = rd_byte;
  assign out_data.last_byte = out_last;

endmodule

>>> sv/sh384_dp.sv
module sh384_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sh384_pkg::dp_cmd_t cmd,
  output logic [7:0]        rd_byte
);

  sh384_pkg::state_t st_r;
  sh384_pkg::state_t st_nxt;
  logic [sh384_pkg::WIDX_W-1:0] rd_widx;

  // XOR one byte into the state, bytes packed little-endian into words.
  function automatic sh384_pkg::state_t xor_byte(sh384_pkg::state_t s,
                                                  logic [sh384_pkg::POS_W-1:0] pos,
                                                  logic [7:0] v);
    sh384_pkg::state_t t;
    logic [sh384_pkg::WIDX_W-1:0] w;
    t = s;
    w = sh384_pkg::WIDX_W'(pos >> 2);
    for (int i = 0; i < sh384_pkg::NUM_WORDS; i++) begin
      if (w == sh384_pkg::WIDX_W'(i)) begin
        t[i] = t[i] ^ (32'(v) << {pos[1:0], 3'b000});
      end
    end
    return t;
  endfunction

  // One round: four independent column mixes, then the round's swap and constant.
  function automatic sh384_pkg::state_t round_fn(sh384_pkg::state_t s,
                                                  logic [sh384_pkg::RND_W-1:0] r);
    sh384_pkg::state_t t;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] d;
    logic [31:0] tmp;
    t = s;
    for (int c = 0; c < 4; c++) begin
      a = {s[c][7:0], s[c][31:8]};
      b = {s[c+4][22:0], s[c+4][31:23]};
      d = s[c+8];
      t[c+8] = a ^ (d << 1) ^ ((b & d) << 2);
      t[c+4] = b ^ a ^ ((a | d) << 1);
      t[c]   = d ^ b ^ ((a & b) << 3);
    end
    if (r[1:0] == 2'd0) begin
      tmp  = t[0];
      t[0] = t[1];
      t[1] = tmp;
      tmp  = t[2];
      t[2] = t[3];
      t[3] = tmp;
      t[0] = t[0] ^ sh384_pkg::ROUND_CONST ^ 32'(r);
    end else if (r[1:0] == 2'd2) begin
      tmp  = t[0];
      t[0] = t[2];
      t[2] = tmp;
      tmp  = t[1];
      t[1] = t[3];
      t[3] = tmp;
    end
    return t;
  endfunction

  always_comb begin
    st_nxt = st_r;
    unique case (cmd.op)
      sh384_pkg::DP_HOLD:   st_nxt = st_r;
      sh384_pkg::DP_ABSORB: st_nxt = xor_byte(st_r, cmd.pos, cmd.data);
      sh384_pkg::DP_PAD:    st_nxt = xor_byte(xor_byte(st_r, cmd.pos, sh384_pkg::PAD_FIRST),
                                              sh384_pkg::POS_W'(sh384_pkg::RATE_BYTES - 1),
                                              sh384_pkg::PAD_LAST);
      sh384_pkg::DP_ROUND:  st_nxt = round_fn(st_r, cmd.rnd);
      sh384_pkg::DP_CLEAR:  st_nxt = '0;
      default:              st_nxt = st_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign rd_widx = sh384_pkg::WIDX_W'(cmd.pos >> 2);
  assign rd_byte = 8'(st_r[rd_widx] >> {cmd.pos[1:0], 3'b000});

endmodule

>>> sv/sh384_ctrl.sv
module sh384_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sh384_pkg::in_item_t         in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sh384_pkg::CFG_W-1:0] cfg_out_length,
  output sh384_pkg::dp_cmd_t          cmd
);

  sh384_pkg::ctrl_state_t state_r, state_nxt;
  logic [sh384_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic [sh384_pkg::POS_W-1:0] rate_pos_r, rate_pos_nxt;
  logic [sh384_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [sh384_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  logic [sh384_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                        sq_r, sq_nxt;
  logic [sh384_pkg::CFG_W-1:0] out_length_r;
  logic [sh384_pkg::LEN_W-1:0] len_sat;
  logic                        in_acc;
  logic                        out_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != sh384_pkg::ST_IDLE);
  assign out_valid = (state_r == sh384_pkg::ST_SQUEEZE);
  assign out_last  = (sh384_pkg::LEN_W'(cnt_r + 1'b1) == len_r);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign len_sat = (out_length_r > sh384_pkg::CFG_W'(sh384_pkg::MAX_OUT_BYTES)) ?
                   sh384_pkg::LEN_W'(sh384_pkg::MAX_OUT_BYTES) :
                   sh384_pkg::LEN_W'(out_length_r);

  always_comb begin
    state_nxt    = state_r;
    rnd_nxt      = rnd_r;
    rate_pos_nxt = rate_pos_r;
    out_pos_nxt  = out_pos_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    sq_nxt       = sq_r;
    cmd.op       = sh384_pkg::DP_HOLD;
    cmd.pos      = rate_pos_r;
    cmd.data     = in_data.data_byte;
    cmd.rnd      = rnd_r;
    unique case (state_r)
      sh384_pkg::ST_IDLE: begin
        if (in_acc) begin
          rnd_nxt = '0;
          if (in_data.command == sh384_pkg::CMD_ABSORB) begin
            cmd.op = sh384_pkg::DP_ABSORB;
            sq_nxt = 1'b0;
            if (rate_pos_r == sh384_pkg::POS_W'(sh384_pkg::RATE_BYTES - 1)) begin
              rate_pos_nxt = '0;
              state_nxt    = sh384_pkg::ST_PERM;
            end else begin
              rate_pos_nxt = rate_pos_r + 1'b1;
            end
          end else begin
            cmd.op       = sh384_pkg::DP_PAD;
            sq_nxt       = 1'b1;
            len_nxt      = len_sat;
            cnt_nxt      = '0;
            out_pos_nxt  = '0;
            rate_pos_nxt = '0;
            state_nxt    = sh384_pkg::ST_PERM;
          end
        end
      end
      sh384_pkg::ST_PERM: begin
        cmd.op = sh384_pkg::DP_ROUND;
        if (rnd_r == sh384_pkg::RND_W'(sh384_pkg::ROUNDS - 1)) begin
          rnd_nxt = '0;
          if (!sq_r) begin
            state_nxt = sh384_pkg::ST_IDLE;
          end else if (cnt_r == len_r) begin
            // Zero hash bytes requested: nothing to squeeze, just wipe the state.
            state_nxt = sh384_pkg::ST_CLEAR;
          end else begin
            state_nxt = sh384_pkg::ST_SQUEEZE;
          end
        end else begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      sh384_pkg::ST_SQUEEZE: begin
        cmd.pos = out_pos_r;
        if (out_acc) begin
          if (out_last) begin
            cmd.op    = sh384_pkg::DP_CLEAR;
            sq_nxt    = 1'b0;
            state_nxt = sh384_pkg::ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            if (out_pos_r == sh384_pkg::POS_W'(sh384_pkg::RATE_BYTES - 1)) begin
              out_pos_nxt = '0;
              rnd_nxt     = '0;
              state_nxt   = sh384_pkg::ST_PERM;
            end else begin
              out_pos_nxt = out_pos_r + 1'b1;
            end
          end
        end
      end
      sh384_pkg::ST_CLEAR: begin
        cmd.op    = sh384_pkg::DP_CLEAR;
        sq_nxt    = 1'b0;
        state_nxt = sh384_pkg::ST_IDLE;
      end
      default: state_nxt = sh384_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sh384_pkg::ST_IDLE;
      rnd_r        <= '0;
      rate_pos_r   <= '0;
      out_pos_r    <= '0;
      cnt_r        <= '0;
      len_r        <= '0;
      sq_r         <= 1'b0;
      out_length_r <= sh384_pkg::OUT_LENGTH_RESET;
    end else begin
      state_r    <= state_nxt;
      rnd_r      <= rnd_nxt;
      rate_pos_r <= rate_pos_nxt;
      out_pos_r  <= out_pos_nxt;
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
      sq_r       <= sq_nxt;
      if (cfg_valid && cfg_ready) begin
        out_length_r <= cfg_out_length;
      end
    end
  end

endmodule

>>> sv/sh384_chk.sv
`include "sponge_hash_384bit_permutation_assert.svh"

module sh384_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input sh384_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input sh384_pkg::out_item_t out_data
);

  logic in_acc;
  logic out_acc;
  logic out_held;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_held = out_valid && out_stall;

  // No new message byte may enter while the hash is being squeezed.
  `SH384_ASSERT(a_no_input_while_squeeze, out_valid |-> in_stall, "input taken during squeeze")

  `SH384_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "output valid right after reset")

  `SH384_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_data), "stalled output changed")

  // A finish always starts a permutation, so the next cycle cannot take input.
  `SH384_ASSERT(a_finish_busy, in_acc && in_data.command |=> in_stall, "finish did not stall input")

  // The final hash byte ends the transaction stream of a message.
  `SH384_ASSERT(a_last_ends, out_acc && out_data.last_byte |=> !out_valid, "output after last byte")

endmodule

bind sponge_hash_384bit_permutation sh384_chk u_sh384_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
